@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with synchronous active-low reset as the disable.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Same, with a caller-supplied message.
`define ASSERT_CLK_MSG(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

@@ hw/rtl/ipd_pkg.sv @@
package ipd_pkg;

  localparam int FRAME_BITS = 16;
  localparam int TIME_BITS  = 16;
  localparam int PAUSE_W    = 16;
  localparam int MSG_W      = 16;
  localparam int CNT_W      = $clog2(FRAME_BITS);
  localparam int NUM_REGS   = 8;
  localparam int REG_SEL_W  = $clog2(NUM_REGS);
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [REG_SEL_W-1:0] REG_START_LO  = REG_SEL_W'(0);
  localparam logic [REG_SEL_W-1:0] REG_START_HI  = REG_SEL_W'(1);
  localparam logic [REG_SEL_W-1:0] REG_REPEAT_LO = REG_SEL_W'(2);
  localparam logic [REG_SEL_W-1:0] REG_REPEAT_HI = REG_SEL_W'(3);
  localparam logic [REG_SEL_W-1:0] REG_ONE_LO    = REG_SEL_W'(4);
  localparam logic [REG_SEL_W-1:0] REG_ONE_HI    = REG_SEL_W'(5);
  localparam logic [REG_SEL_W-1:0] REG_ZERO_LO   = REG_SEL_W'(6);
  localparam logic [REG_SEL_W-1:0] REG_ZERO_HI   = REG_SEL_W'(7);

  localparam logic [TIME_BITS-1:0] REG_RESET [NUM_REGS] = '{
    TIME_BITS'(4000), TIME_BITS'(5000), TIME_BITS'(2200), TIME_BITS'(2800),
    TIME_BITS'(1390), TIME_BITS'(1990), TIME_BITS'(260),  TIME_BITS'(860)
  };

  typedef enum logic {
    PH_IDLE,
    PH_DATA
  } phase_t;

  typedef struct packed {
    logic [MSG_W-1:0] message;
    logic             is_command;
    logic [4:0]       command_value;
    logic [9:0]       hit_value;
    logic             checksum_ok;
    logic             is_repeat;
  } ipd_result_t;

  function automatic ipd_result_t make_result(input logic [MSG_W-1:0] msg,
                                              input logic rep);
    ipd_result_t res;
    res.message       = msg;
    res.is_command    = (msg[5:1] == 5'd0);
    res.command_value = msg[10:6];
    res.hit_value     = msg[10:1];
    res.checksum_ok   = ((msg[5:1] ^ msg[10:6]) == msg[15:11]);
    res.is_repeat     = rep;
    return res;
  endfunction

endpackage

@@ hw/rtl/ipd_in_stage.sv @@
module ipd_in_stage import ipd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PAUSE_W-1:0]   in_pause_us,
  input  logic                 advance,
  output logic                 s1_valid,
  output logic [TIME_BITS-1:0] s1_pause
);

  logic                 valid_r;
  logic                 valid_nxt;
  logic [TIME_BITS-1:0] pause_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload: load on every accepted beat
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pause_r <= TIME_BITS'(in_pause_us);
    end
  end

  assign s1_valid = valid_r;
  assign s1_pause = pause_r;

endmodule

@@ hw/rtl/ipd_core.sv @@
module ipd_core import ipd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic [TIME_BITS-1:0]  pause,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  res_valid,
  output ipd_result_t           res
);

  logic [TIME_BITS-1:0]  cfg_r [NUM_REGS];
  phase_t                phase_r, phase_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [FRAME_BITS-1:0] shift_r, shift_nxt;
  logic [MSG_W-1:0]      last_r, last_nxt;

  logic                  hit_start, hit_rep, hit_one, hit_zero;
  logic                  last_bit;
  logic [FRAME_BITS-1:0] shift_set;
  logic [MSG_W-1:0]      frame_msg;
  logic                  ev_repeat, ev_bit, ev_done, ev_abort, ev_open;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_r[i] <= REG_RESET[i];
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      cfg_r[cfg_index[REG_SEL_W-1:0]] <= TIME_BITS'(cfg_data);
    end
  end

  // strict range tests on both ends
  assign hit_start = (pause > cfg_r[REG_START_LO])  && (pause < cfg_r[REG_START_HI]);
  assign hit_rep   = (pause > cfg_r[REG_REPEAT_LO]) && (pause < cfg_r[REG_REPEAT_HI]);
  assign hit_one   = (pause > cfg_r[REG_ONE_LO])    && (pause < cfg_r[REG_ONE_HI]);
  assign hit_zero  = (pause > cfg_r[REG_ZERO_LO])   && (pause < cfg_r[REG_ZERO_HI]);

  assign last_bit = (cnt_r == CNT_W'(FRAME_BITS - 1));

  always_comb begin
    shift_set        = shift_r;
    shift_set[cnt_r] = hit_one;
  end

  assign frame_msg = MSG_W'(shift_set);

  assign ev_open   = fire && (phase_r == PH_IDLE) && hit_start;
  assign ev_repeat = fire && (phase_r == PH_IDLE) && !hit_start && hit_rep;
  assign ev_bit    = fire && (phase_r == PH_DATA) && (hit_one || hit_zero);
  assign ev_abort  = fire && (phase_r == PH_DATA) && !(hit_one || hit_zero);
  assign ev_done   = ev_bit && last_bit;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    last_nxt  = last_r;
    if (ev_open || ev_abort) begin
      phase_nxt = ev_open ? PH_DATA : PH_IDLE;
      cnt_nxt   = '0;
      shift_nxt = '0;
    end else if (ev_done) begin
      phase_nxt = PH_IDLE;
      cnt_nxt   = '0;
      shift_nxt = '0;
      last_nxt  = frame_msg;
    end else if (ev_bit) begin
      cnt_nxt   = cnt_r + CNT_W'(1);
      shift_nxt = shift_set;
    end
  end

  // result
  always_comb begin
    res_valid = ev_repeat || ev_done;
    res       = make_result(ev_repeat ? last_r : frame_msg, ev_repeat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      shift_r <= '0;
      last_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      shift_r <= shift_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

@@ hw/rtl/ipd_out_reg.sv @@
module ipd_out_reg import ipd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic        res_valid,
  input  ipd_result_t res,
  output logic        advance,
  output logic        out_valid,
  input  logic        out_ready,
  output ipd_result_t out_res
);

  logic        valid_r, valid_nxt;
  ipd_result_t res_r;

  // slot is free when empty or being drained this cycle
  assign advance   = !valid_r || out_ready;
  assign valid_nxt = advance ? (fire && res_valid) : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

@@ hw/rtl/ir_pulse_distance_decoder.sv @@
// Pulse-distance infrared decoder: each input beat is one measured pause in
// microseconds; a start pause opens a 16-bit frame sent LSB first, one and
// zero pauses add bits, and any other pause inside a frame drops it without
// a result. A repeat pause while idle re-sends the last complete message.
// One pause is taken every cycle while the output is not stalled; each result
// passes the input register and then the result register, with all range
// compares and the bit insert in the single stage between them. A stalled
// result holds the input stage, so the input stalls only while out_ready is
// low with a result waiting. Eight pause-range registers are written through
// the cfg_ port; the user must write them only while the block is idle, which
// the block itself does not enforce. cfg_ready is always high and indexes
// past the last register are ignored.
module ir_pulse_distance_decoder import ipd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PAUSE_W-1:0]    in_pause_us,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [MSG_W-1:0]      out_message,
  output logic                  out_is_command,
  output logic [4:0]            out_command_value,
  output logic [9:0]            out_hit_value,
  output logic                  out_checksum_ok,
  output logic                  out_is_repeat,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                 advance;
  logic                 s1_valid;
  logic [TIME_BITS-1:0] s1_pause;
  logic                 fire;
  logic                 res_valid;
  ipd_result_t          res;
  ipd_result_t          out_res;

  assign cfg_ready = 1'b1;
  assign fire      = s1_valid && advance;

  ipd_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_pause_us (in_pause_us),
    .advance     (advance),
    .s1_valid    (s1_valid),
    .s1_pause    (s1_pause)
  );

  ipd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .pause     (s1_pause),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res       (res)
  );

  ipd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_message       = out_res.message;
  assign out_is_command    = out_res.is_command;
  assign out_command_value = out_res.command_value;
  assign out_hit_value     = out_res.hit_value;
  assign out_checksum_ok   = out_res.checksum_ok;
  assign out_is_repeat     = out_res.is_repeat;

endmodule

@@ hw/rtl/ipd_checker.sv @@
`include "assert_macros.svh"

module ipd_checker import ipd_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [MSG_W-1:0] out_message,
  input logic             out_is_command,
  input logic [4:0]       out_command_value,
  input logic [9:0]       out_hit_value,
  input logic             out_checksum_ok
);

  logic [4:0] player_f;
  logic [4:0] data_f;
  logic       cmd_f;
  logic       sum_ok_f;

  assign player_f = out_message[5:1];
  assign data_f   = out_message[10:6];
  assign cmd_f    = (player_f == 5'd0);
  assign sum_ok_f = ((player_f ^ data_f) == out_message[15:11]);

  // a stalled result beat stays up
  `ASSERT_CLK_MSG(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "beat dropped")

  // an empty result slot never blocks the input side
  `ASSERT_CLK_MSG(a_in_ready_when_empty, clk, rst_n, !out_valid |-> in_ready, "input stalled")

  // split fields follow the message
  `ASSERT_CLK(a_hit_field, clk, rst_n, out_valid |-> out_hit_value == out_message[10:1])

  `ASSERT_CLK(a_cmd_fields, clk, rst_n, out_valid |-> out_command_value == data_f && out_is_command == cmd_f)

  // checksum flag follows the message
  `ASSERT_CLK(a_checksum, clk, rst_n, out_valid |-> out_checksum_ok == sum_ok_f)

endmodule

bind ir_pulse_distance_decoder ipd_checker u_ipd_checker (.*);
